// File: hw/rtl/lse_pkg.sv
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types and constants for the Mercator-series log evaluator.
// ----------------------------------------------------------------------------
package lse_pkg;

   localparam int FRACTION_BITS_DEF = 30;
   localparam int MAX_SPLIT_DEF     = 64;
   localparam int MAX_ROUNDS        = 1024;
   localparam int OUT_FRAC          = 26;

   localparam int X_W        = 32;
   localparam int LN_W       = 32;
   localparam int SPLIT_W    = 7;
   localparam int ROUNDS_W   = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   // multiplier digit width for the shared multiply-accumulate
   localparam int MUL_DIGIT_W = 16;

   localparam logic [SPLIT_W-1:0]  SPLIT_RESET  = 7'd4;
   localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 11'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPLIT_COUNT      = 1'b0,
      CSR_ROUNDS_PER_SPLIT = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHK,
      ST_DIV,
      ST_ADD,
      ST_MAG,
      ST_RND,
      ST_OUT
   } state_type;

endpackage

// File: hw/rtl/lse_req_if.sv
// ----------------------------------------------------------------------------
// lse_req_if
// Request channel: one argument x per beat, unsigned fixed point.
// ----------------------------------------------------------------------------
interface lse_req_if import lse_pkg::*; ();

   logic           valid;
   logic           ready;
   logic [X_W-1:0] x_value;

   modport source (output valid, output x_value, input ready);
   modport sink   (input valid, input x_value, output ready);

endinterface

// File: hw/rtl/lse_rsp_if.sv
// ----------------------------------------------------------------------------
// lse_rsp_if
// Response channel: one saturated Q5.26 log value per beat.
// ----------------------------------------------------------------------------
interface lse_rsp_if import lse_pkg::*; ();

   logic                   valid;
   logic                   ready;
   logic signed [LN_W-1:0] ln_approx;

   modport source (output valid, output ln_approx, input ready);
   modport sink   (input valid, input ln_approx, output ready);

endinterface

// File: hw/rtl/log_series_evaluator.sv
// Each item sums T = split_count * rounds_per_split terms (fewer when the power of |x-1|
// underflows to zero). Per term the shared 16-bit-digit multiply-accumulate steps through
// the multiplier digits, most significant first, and the one-bit-per-cycle restoring divider
// forms the quotient; one item is in flight at a time.
// Reset: split_count returns to 4, rounds_per_split to 256, sequencer and response
// valid are cleared; there is no clearing pass.
// ----------------------------------------------------------------------------
// log_series_evaluator
// ln(x) by the Mercator series with a shared multiplier and serial divider.
// ----------------------------------------------------------------------------
module log_series_evaluator
   import lse_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF,
   parameter int MAX_SPLIT     = MAX_SPLIT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   lse_req_if.sink               req_bus,
   lse_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ONE_W   = FRACTION_BITS + 1;
   localparam int ND      = (ONE_W + MUL_DIGIT_W - 1) / MUL_DIGIT_W;
   localparam int DM_W    = ND * MUL_DIGIT_W;
   localparam int PA_W    = ONE_W + DM_W;
   localparam int DG_W    = (ND > 1) ? $clog2(ND) : 1;
   localparam int TOT_MAX = MAX_SPLIT * MAX_ROUNDS;
   localparam int TW      = $clog2(TOT_MAX + 1);
   localparam int SPW     = $clog2(MAX_SPLIT + 1);
   localparam int QW      = ((ONE_W > TW) ? ONE_W : TW) + 1;
   localparam int CW      = $clog2(QW);
   localparam int SW      = QW + TW + 1;
   localparam int XW      = (FRACTION_BITS + 2 > X_W) ? FRACTION_BITS + 2 : X_W;
   localparam int RSH     = (FRACTION_BITS > OUT_FRAC) ? FRACTION_BITS - OUT_FRAC : 0;
   localparam int LSH     = (FRACTION_BITS < OUT_FRAC) ? OUT_FRAC - FRACTION_BITS : 0;
   localparam int RW      = SW + LSH + 1;
   localparam int RND_SH  = (RSH > 0) ? RSH - 1 : 0;

   localparam logic [XW-1:0]   ONE_X    = XW'(1) << FRACTION_BITS;
   localparam logic [XW-1:0]   TWO_X    = ONE_X << 1;
   localparam logic [ONE_W-1:0] ONE_PW  = ONE_W'(1) << FRACTION_BITS;
   localparam logic [RW-1:0]   RND_HALF = (RSH > 0) ? (RW'(1) << RND_SH) : '0;
   localparam logic [RW-1:0]   NEG_LIM  = RW'(64'h0000_0000_8000_0000);
   localparam logic [RW-1:0]   POS_LIM  = RW'(64'h0000_0000_7FFF_FFFF);
   localparam logic [DG_W-1:0] DIG_LAST = DG_W'(ND - 1);
   localparam logic [CW-1:0]   CNT_LAST = CW'(QW - 1);

   // configuration
   logic [SPLIT_W-1:0]  split_count_ff;
   logic [ROUNDS_W-1:0] rounds_ff;

   // sequencer and datapath
   state_type          state_ff, state_in;
   logic               dneg_ff, dneg_in;
   logic [DM_W-1:0]    dmag_ff, dmag_in;
   logic [ONE_W-1:0]   pw_ff, pw_in;
   logic [PA_W-1:0]    acc_ff, acc_in;
   logic [DG_W-1:0]    dig_ff, dig_in;
   logic [TW-1:0]      total_ff, total_in;
   logic [TW-1:0]      n_ff, n_in;
   logic [QW-1:0]      quo_ff, quo_in;
   logic [TW-1:0]      rem_ff, rem_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [SW-1:0]      sum_ff, sum_in;
   logic               sneg_ff, sneg_in;
   logic [SW-1:0]      mag_ff, mag_in;
   logic [LN_W-1:0]    res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LN_W-1:0]    rsp_data_ff, rsp_data_in;

   // control from the output decode
   logic req_ready;
   logic req_fire;
   logic rsp_load;

   // combinational helpers
   logic [SPW-1:0]             splits_c;
   logic [ROUNDS_W-1:0]        rounds_c;
   logic [TW-1:0]              total_c;
   logic [XW-1:0]              x_ext_c;
   logic [XW-1:0]              x_sat_c;
   logic                       dneg_c;
   logic [XW-1:0]              dmag_x_c;
   logic [MUL_DIGIT_W-1:0]     digit_c;
   logic [ONE_W+MUL_DIGIT_W-1:0] prod_c;
   logic [ONE_W-1:0]           pw_new_c;
   logic [TW:0]                rem_sh_c;
   logic [TW:0]                n_ext_c;
   logic                       ge_c;
   logic                       tneg_c;
   logic [RW-1:0]              r_c;

   // ---------------------------------------------------------------- decode
   always_comb begin
      splits_c = (int'(split_count_ff) > MAX_SPLIT) ? SPW'(MAX_SPLIT) : SPW'(split_count_ff);
      rounds_c = (rounds_ff > ROUNDS_W'(MAX_ROUNDS)) ? ROUNDS_W'(MAX_ROUNDS) : rounds_ff;
      total_c  = TW'(splits_c) * TW'(rounds_c);

      x_ext_c  = XW'(req_bus.x_value);
      x_sat_c  = (x_ext_c > TWO_X) ? TWO_X : x_ext_c;
      dneg_c   = x_sat_c < ONE_X;
      dmag_x_c = dneg_c ? ONE_X - x_sat_c : x_sat_c - ONE_X;

      digit_c  = dmag_ff[dig_ff*MUL_DIGIT_W +: MUL_DIGIT_W];
      prod_c   = pw_ff * digit_c;
      pw_new_c = acc_ff[FRACTION_BITS +: ONE_W];

      rem_sh_c = {rem_ff, quo_ff[QW-1]};
      n_ext_c  = {1'b0, n_ff};
      ge_c     = rem_sh_c >= n_ext_c;

      // odd terms are positive only when x >= 1
      tneg_c   = dneg_ff || !n_ff[0];

      r_c = (RSH > 0) ? ((RW'(mag_ff) + RND_HALF) >> RSH) : (RW'(mag_ff) << LSH);
   end

   // ------------------------------------------------------- output decode
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_bus.ready);
   end

   assign req_fire = req_bus.valid && req_ready;

   // ---------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (total_c == '0) ? ST_MAG : ST_MUL;
            end
         end
         ST_MUL: begin
            if (dig_ff == '0) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            // power underflowed: every later term is zero
            state_in = (pw_new_c == '0) ? ST_MAG : ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            state_in = (n_ff == total_ff) ? ST_MAG : ST_MUL;
         end
         ST_MAG: begin
            state_in = ST_RND;
         end
         ST_RND: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------ datapath
   always_comb begin
      dneg_in      = dneg_ff;
      dmag_in      = dmag_ff;
      pw_in        = pw_ff;
      acc_in       = acc_ff;
      dig_in       = dig_ff;
      total_in     = total_ff;
      n_in         = n_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      sneg_in      = sneg_ff;
      mag_in       = mag_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               dneg_in  = dneg_c;
               dmag_in  = DM_W'(dmag_x_c);
               pw_in    = ONE_PW;
               acc_in   = '0;
               dig_in   = DIG_LAST;
               total_in = total_c;
               n_in     = TW'(1);
               sum_in   = '0;
            end
         end
         ST_MUL: begin
            // most significant digit first
            acc_in = (acc_ff << MUL_DIGIT_W) + PA_W'(prod_c);
            dig_in = dig_ff - DG_W'(1);
         end
         ST_CHK: begin
            pw_in  = pw_new_c;
            quo_in = QW'(pw_new_c) + QW'(n_ff >> 1);
            rem_in = '0;
            cnt_in = CNT_LAST;
         end
         ST_DIV: begin
            rem_in = ge_c ? TW'(rem_sh_c - n_ext_c) : TW'(rem_sh_c);
            quo_in = {quo_ff[QW-2:0], ge_c};
            cnt_in = cnt_ff - CW'(1);
         end
         ST_ADD: begin
            sum_in = tneg_c ? sum_ff - SW'(quo_ff) : sum_ff + SW'(quo_ff);
            n_in   = n_ff + TW'(1);
            acc_in = '0;
            dig_in = DIG_LAST;
         end
         ST_MAG: begin
            sneg_in = sum_ff[SW-1];
            mag_in  = sum_ff[SW-1] ? SW'(0) - sum_ff : sum_ff;
         end
         ST_RND: begin
            if (sneg_ff) begin
               res_in = (r_c >= NEG_LIM) ? LN_W'(NEG_LIM) : LN_W'(RW'(0) - r_c);
            end else begin
               res_in = (r_c >= POS_LIM) ? LN_W'(POS_LIM) : LN_W'(r_c);
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
         end
      endcase
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         split_count_ff <= SPLIT_RESET;
         rounds_ff      <= ROUNDS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en && csr_index == CSR_SPLIT_COUNT) begin
            split_count_ff <= csr_wdata[SPLIT_W-1:0];
         end
         if (csr_wr_en && csr_index == CSR_ROUNDS_PER_SPLIT) begin
            rounds_ff <= csr_wdata[ROUNDS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      dneg_ff     <= dneg_in;
      dmag_ff     <= dmag_in;
      pw_ff       <= pw_in;
      acc_ff      <= acc_in;
      dig_ff      <= dig_in;
      total_ff    <= total_in;
      n_ff        <= n_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      sum_ff      <= sum_in;
      sneg_ff     <= sneg_in;
      mag_ff      <= mag_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_bus.ready     = req_ready;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.ln_approx = signed'(rsp_data_ff);

   // ----------------------------------------------------------- assertions
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_bus.ready)
      else $error("request taken while an item is in flight");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < n_ff))
      else $error("divider remainder not below term index");

   a_term_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL || state_ff == ST_CHK || state_ff == ST_DIV || state_ff == ST_ADD)
      |-> (n_ff != '0 && n_ff <= total_ff))
      else $error("term index outside series length");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending result overwritten");

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Mercator-series log evaluator. Request beats are
// fed from a queue with random gaps; a bit-exact predictor of the series sum
// (truncated powers, rounded term division, Q5.26 rounding and saturation)
// is queued per accepted beat and compared with each response beat. Register
// settings range over defaults, zero terms, saturating counts and small mixes.
// ----------------------------------------------------------------------------
module tb
   import lse_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB          = FRACTION_BITS_DEF;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int HOLDOFF_BEAT   = 24;
   localparam int HOLDOFF_CYCLES = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lse_req_if req_if ();
   lse_rsp_if rsp_if ();

   log_series_evaluator uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // bench copy of the two registers
   logic [SPLIT_W-1:0]  split_cfg  = SPLIT_RESET;
   logic [ROUNDS_W-1:0] rounds_cfg = ROUNDS_RESET;

   logic [X_W-1:0]          x_pending[$];
   logic signed [LN_W-1:0]  ln_expected[$];

   int   req_beats      = 0;
   int   results_seen   = 0;
   int   mismatch_count = 0;
   int   settings_run   = 0;
   int   cycle_count    = 0;
   int   send_gap       = 0;
   int   stall_left     = 0;
   int   holdoff_left   = 0;
   logic holdoff_used   = 1'b0;
   logic quiet_tail     = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // series sum ln(x) = sum (-1)^(n+1) d^n / n, d = x - 1, rounded into Q5.26
   function automatic logic signed [LN_W-1:0] series_ln(input logic [X_W-1:0] x_in,
                                                         input logic [SPLIT_W-1:0] split_in,
                                                         input logic [ROUNDS_W-1:0] rounds_in);
      logic [63:0]        one_fx;
      logic [63:0]        x_fx;
      logic [63:0]        d_mag;
      logic [63:0]        power;
      logic [63:0]        term;
      logic [63:0]        mag;
      logic [63:0]        rounded;
      logic [63:0]        negated;
      logic [127:0]       prod;
      logic signed [63:0] acc;
      logic               d_neg;
      logic               s_neg;
      int unsigned        splits;
      int unsigned        rounds;
      int unsigned        total;
      int                 sh;
      one_fx = 64'd1 << FB;
      x_fx   = {32'd0, x_in};
      if (x_fx > 2 * one_fx) begin
         x_fx = 2 * one_fx;
      end
      d_neg  = x_fx < one_fx;
      d_mag  = d_neg ? one_fx - x_fx : x_fx - one_fx;
      splits = (split_in > MAX_SPLIT_DEF) ? MAX_SPLIT_DEF : split_in;
      rounds = (rounds_in > MAX_ROUNDS) ? MAX_ROUNDS : rounds_in;
      total  = splits * rounds;
      power  = one_fx;
      acc    = 64'sd0;
      for (int unsigned n = 1; n <= total; n++) begin
         prod  = {64'd0, power} * {64'd0, d_mag};
         power = prod[FB +: 64];
         if (power == 64'd0) begin
            break;
         end
         term = (power + 64'(n / 2)) / 64'(n);
         if (d_neg || (n[0] == 1'b0)) begin
            acc = acc - $signed(term);
         end else begin
            acc = acc + $signed(term);
         end
      end
      s_neg = acc < 0;
      mag   = s_neg ? 64'd0 - acc : acc;
      if (FB > OUT_FRAC) begin
         sh      = FB - OUT_FRAC;
         rounded = (mag + (64'd1 << (sh - 1))) >> sh;
      end else begin
         sh      = OUT_FRAC - FB;
         rounded = mag << sh;
      end
      if (s_neg) begin
         negated = 64'd0 - rounded;
         return (rounded >= 64'h8000_0000) ? 32'sh8000_0000 : negated[LN_W-1:0];
      end
      return (rounded >= 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : rounded[LN_W-1:0];
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.x_value <= '0;
         send_gap       <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            ln_expected.push_back(series_ln(req_if.x_value, split_cfg, rounds_cfg));
            void'(x_pending.pop_front());
            req_beats <= req_beats + 1;
         end
         if (req_if.valid && !req_if.ready) begin
            // beat still offered, hold it
         end else if (send_gap > 0) begin
            send_gap     <= send_gap - 1;
            req_if.valid <= 1'b0;
         end else if (x_pending.size() > 0 && !quiet_tail && $urandom_range(0, 7) == 0) begin
            send_gap     <= $urandom_range(0, 12);
            req_if.valid <= 1'b0;
         end else if (x_pending.size() > 0) begin
            req_if.valid   <= 1'b1;
            req_if.x_value <= x_pending[0];
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // one long response hold-off so the block backs up onto its input
   always @(posedge clock) begin
      if (!holdoff_used && req_beats == HOLDOFF_BEAT) begin
         holdoff_left <= HOLDOFF_CYCLES;
         holdoff_used <= 1'b1;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   // response monitor
   always @(posedge clock) begin : rsp_check
      logic signed [LN_W-1:0] want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen <= results_seen + 1;
            if (ln_expected.size() == 0) begin
               $error("unexpected response beat: ln_approx %0d", rsp_if.ln_approx);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = ln_expected.pop_front();
               if (rsp_if.ln_approx !== want) begin
                  $error("ln_approx mismatch: expected %0d, got %0d", want, rsp_if.ln_approx);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (holdoff_left > 0) begin
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            rsp_if.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            stall_left   <= $urandom_range(0, 12);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_SPLIT_COUNT) begin
         split_cfg = data[SPLIT_W-1:0];
      end else begin
         rounds_cfg = data[ROUNDS_W-1:0];
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
      end while (x_pending.size() != 0 || ln_expected.size() != 0);
   endtask

   // program both registers, send a batch of arguments, wait for all results
   task automatic run_setting(input logic [CSR_DATA_W-1:0] split_data,
                              input logic [CSR_DATA_W-1:0] rounds_data,
                              input logic [X_W-1:0] xs[$]);
      write_reg(CSR_SPLIT_COUNT, split_data);
      write_reg(CSR_ROUNDS_PER_SPLIT, rounds_data);
      settings_run++;
      foreach (xs[i]) begin
         x_pending.push_back(xs[i]);
      end
      wait_drained();
   endtask

   initial begin
      logic [X_W-1:0]        batch[$];
      logic [CSR_DATA_W-1:0] split_data;
      logic [CSR_DATA_W-1:0] rounds_data;
      req_if.valid   = 1'b0;
      req_if.x_value = '0;
      rsp_if.ready   = 1'b0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_SPLIT_COUNT;
      csr_wdata      = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: full 1024 terms at the ends of the range, d = 0, tiny d
      batch = '{32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h4000_0000, 32'h4000_0001};
      foreach (batch[i]) begin
         x_pending.push_back(batch[i]);
      end
      settings_run++;
      wait_drained();

      // single term
      run_setting(11'd1, 11'd1, '{32'h0000_0000, 32'h8000_0000, 32'h2000_0000});
      // no terms from either register
      run_setting(11'd0, 11'd1, '{32'h6000_0000});
      run_setting(11'd3, 11'd0, '{32'h6000_0000});
      // both counts above their maxima, upper data bits set on the split write
      run_setting(11'h7FF, 11'h7FF, '{32'h4000_0000, 32'h3FFF_FFFF, 32'h4000_4000,
                                      32'h6000_0000, 32'h2000_0000});
      // both counts at their maxima
      run_setting(11'd64, 11'd1024, '{32'h5555_5555, 32'h2AAA_AAAA});
      // odd split count
      run_setting(11'd3, 11'd5, '{32'h0000_0001, 32'h7FFF_FFFF, 32'h3000_0000});

      for (int p = 0; p < 10; p++) begin
         if (p >= 8) begin
            quiet_tail = 1'b1;
         end
         case ($urandom_range(0, 7))
            0: begin
               split_data  = {4'($urandom), 7'($urandom_range(65, 127))};
               rounds_data = 11'($urandom_range(0, 1));
            end
            1: begin
               split_data  = {4'($urandom), 7'd0};
               rounds_data = 11'($urandom);
            end
            default: begin
               split_data  = {4'($urandom), 7'($urandom_range(1, 6))};
               rounds_data = 11'($urandom_range(0, 12));
            end
         endcase
         batch.delete();
         for (int k = 0; k < 8; k++) begin
            case ($urandom_range(0, 9))
               0, 1, 2: batch.push_back($urandom());
               3, 4, 5: batch.push_back($urandom_range(0, 32'h8000_0000));
               // close to 1.0, where the powers vanish quickly
               6, 7, 8: batch.push_back(32'h3F80_0000 + $urandom_range(0, 32'h0100_0000));
               default: begin
                  case ($urandom_range(0, 3))
                     0: batch.push_back(32'h0000_0000);
                     1: batch.push_back(32'h8000_0000);
                     2: batch.push_back(32'hFFFF_FFFF);
                     default: batch.push_back(32'h4000_0000);
                  endcase
               end
            endcase
         end
         run_setting(split_data, rounds_data, batch);
      end

      repeat (200) @(posedge clock);
      $display("checked %0d log results over %0d register settings, %0d mismatches",
               results_seen, settings_run, mismatch_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: log_series_evaluator.f
hw/rtl/lse_pkg.sv
hw/rtl/lse_req_if.sv
hw/rtl/lse_rsp_if.sv
hw/rtl/log_series_evaluator.sv
bench/tb.sv
